// ===== sv/mdcf_pkg.sv =====
// Shared constants, types and sequencer states for the collision filter.
// No dependencies.
package mdcf_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int CoordW = 16;
  localparam int DistW = 2 * CoordW + 1;
  localparam int AddrW = 3;
  localparam logic [AddrW-1:0] RegRadius = 3'd0;
  localparam logic [AddrW-1:0] RegGap = 3'd4;

  typedef enum logic [10:0] {
    S_LOAD   = 11'b00000000001,
    S_RDI    = 11'b00000000010,
    S_LDI    = 11'b00000000100,
    S_RDJ    = 11'b00000001000,
    S_DX     = 11'b00000010000,
    S_DY     = 11'b00000100000,
    S_CMP    = 11'b00001000000,
    S_SCAN   = 11'b00010000000,
    S_SEL    = 11'b00100000000,
    S_ROW    = 11'b01000000000,
    S_DEC    = 11'b10000000000,
    S_DECEND = 11'b00000000000,
    S_EMIT   = 11'b11000000000,
    S_OUT    = 11'b10100000000
  } state_t;

  typedef struct packed {
    logic             wr;
    logic [IdxW-1:0]  waddr;
    logic [IdxW-1:0]  raddr;
  } ram_ctl_t;
endpackage

// ===== sv/mdcf_ram.sv =====
// Generic single write, single registered read RAM.
// No dependencies.
module mdcf_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/mdcf_sqacc.sv =====
// Shared square-and-accumulate unit: adds |a-b|^2 to a running sum.
// Depends on mdcf_pkg.
module mdcf_sqacc
  import mdcf_pkg::*;
(
  input  logic              clk,
  input  logic              clr,
  input  logic              en,
  input  logic [CoordW-1:0] a,
  input  logic [CoordW-1:0] b,
  output logic [DistW-1:0]  sum
);
  logic [CoordW-1:0]   d;
  logic [2*CoordW-1:0] sq;

  assign d = (a > b) ? a - b : b - a;
  assign sq = d * d;

  always_ff @(posedge clk) begin
    if (clr) begin
      sum <= '0;
    end else if (en) begin
      sum <= sum + {1'b0, sq};
    end
  end
endmodule

// ===== sv/min_distance_collision_filter.sv =====
// Top level of the minimum-distance collision filter: APB registers, sequencer.
// Depends on mdcf_pkg, mdcf_ram, mdcf_sqacc.
//
// Points transfer one per cycle while the block is loading. The point that carries
// last_point (or the 64th point) ends the set, and radius and gap are sampled at that
// transfer; the input then stalls until the last survivor has been handed to the output
// register. With n points every ordered pair goes through one shared square-and-accumulate
// unit, then greedy scans and removals follow, and survivors leave in load order, held
// back while the receiver stalls.
module min_distance_collision_filter
  import mdcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              valid_in,
  output logic              stall_in,
  input  logic [CoordW-1:0] x_pos,
  input  logic [CoordW-1:0] y_pos,
  input  logic              last_point,
  output logic              valid_out,
  input  logic              stall_out,
  output logic [CoordW-1:0] kept_x,
  output logic [CoordW-1:0] kept_y,
  output logic [IdxW-1:0]   kept_index,
  output logic              final_result
);
  logic [9:0]           radius;
  logic signed [10:0]   gap;
  state_t               state;
  logic [CntW-1:0]      count;
  logic [IdxW-1:0]      i, j, pidx, best;
  logic                 pv;
  logic [MaxPoints-1:0] removed, row_acc, row_wdata, row_rd;
  logic                 row_we;
  logic [CntW-1:0]      cnt_acc, best_cnt, cnt_wdata, cnt_rd;
  logic [DistW-1:0]     lim;
  logic                 thr_pos;
  logic                 hit, scan_take, dec_hit;
  ram_ctl_t             rc, cc;
  logic [CoordW-1:0]    xr, yr, xi, yi, acc_a, acc_b;
  logic                 acc_clr, acc_en;
  logic [DistW-1:0]     d2;
  logic signed [12:0]   thr;
  logic [16:0]          thr16;
  logic [33:0]          thr_sq;
  logic [IdxW-1:0]      last_idx;
  logic [IdxW-1:0]      next_live;
  logic                 have_next;

  assign pready = 1'b1;
  assign prdata = (paddr == RegGap) ? {{21{gap[10]}}, gap} : {22'd0, radius};
  assign stall_in = (state != S_LOAD);
  assign last_idx = IdxW'(count - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
      gap <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == RegRadius) radius <= pwdata[9:0];
      else if (paddr == RegGap) gap <= pwdata[10:0];
    end
  end

  always_comb begin
    rc.wr = 1'b0;
    rc.waddr = IdxW'(count);
    rc.raddr = j;
    case (state)
      S_LOAD: rc.wr = valid_in;
      S_RDI, S_EMIT: rc.raddr = i;
      default: rc.raddr = j;
    endcase
  end

  mdcf_ram #(.Width(CoordW), .Depth(MaxPoints)) u_xram (
    .clk(clk), .we(rc.wr), .waddr(rc.waddr), .wdata(x_pos), .raddr(rc.raddr), .rdata(xr));
  mdcf_ram #(.Width(CoordW), .Depth(MaxPoints)) u_yram (
    .clk(clk), .we(rc.wr), .waddr(rc.waddr), .wdata(y_pos), .raddr(rc.raddr), .rdata(yr));

  assign hit = thr_pos && (i != j) && (d2 < lim);
  assign row_wdata = row_acc | (MaxPoints'(hit) << j);
  assign row_we = (state == S_CMP) && (j == last_idx);

  mdcf_ram #(.Width(MaxPoints), .Depth(MaxPoints)) u_rowram (
    .clk(clk), .we(row_we), .waddr(i), .wdata(row_wdata), .raddr(best), .rdata(row_rd));

  assign scan_take = pv && !removed[pidx] && (cnt_rd > best_cnt);
  assign dec_hit = pv && row_rd[pidx] && !removed[pidx] && (cnt_rd != '0);

  always_comb begin
    cc.wr = 1'b0;
    cc.waddr = i;
    cc.raddr = i;
    cnt_wdata = cnt_acc + CntW'(hit);
    case (state)
      S_CMP: cc.wr = (j == last_idx);
      S_DEC, S_DECEND: begin
        cc.wr = dec_hit;
        cc.waddr = pidx;
        cnt_wdata = cnt_rd - 1'b1;
      end
      default: cc.wr = 1'b0;
    endcase
  end

  mdcf_ram #(.Width(CntW), .Depth(MaxPoints)) u_cntram (
    .clk(clk), .we(cc.wr), .waddr(cc.waddr), .wdata(cnt_wdata), .raddr(cc.raddr),
    .rdata(cnt_rd));

  assign acc_clr = (state == S_LDI) || (state == S_RDJ);
  assign acc_en = (state == S_DX) || (state == S_DY);
  assign acc_a = (state == S_DX) ? xi : yi;
  assign acc_b = (state == S_DX) ? xr : yr;
  mdcf_sqacc u_acc (
    .clk(clk), .clr(acc_clr), .en(acc_en), .a(acc_a), .b(acc_b), .sum(d2));

  assign thr = 13'(signed'({3'b000, radius})) * 13'sd2 + 13'(gap);
  assign thr16 = {thr[12:0], 4'b0000};
  assign thr_sq = {17'd0, thr16} * {17'd0, thr16};

  always_comb begin
    next_live = i;
    have_next = 1'b0;
    for (int k = MaxPoints - 1; k >= 0; k--) begin
      if (k > int'(i) && k < int'(count) && !removed[k]) begin
        next_live = IdxW'(k);
        have_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      removed <= '0;
      valid_out <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (valid_in) begin
            count <= count + 1'b1;
            if (last_point || count == CntW'(MaxPoints - 1)) begin
              thr_pos <= (thr > 0);
              lim <= thr_sq[DistW-1:0];
              i <= '0;
              removed <= '0;
              state <= S_RDI;
            end
          end
        end
        S_RDI: begin
          j <= '0;
          row_acc <= '0;
          cnt_acc <= '0;
          state <= S_LDI;
        end
        S_LDI: begin
          xi <= xr;
          yi <= yr;
          state <= S_DX;
        end
        S_RDJ: state <= S_DX;
        S_DX: state <= S_DY;
        S_DY: state <= S_CMP;
        S_CMP: begin
          row_acc <= row_wdata;
          cnt_acc <= cnt_wdata;
          if (j == last_idx) begin
            if (i == last_idx) begin
              i <= '0;
              pv <= 1'b0;
              best <= '0;
              best_cnt <= '0;
              state <= S_SCAN;
            end else begin
              i <= i + 1'b1;
              state <= S_RDI;
            end
          end else begin
            j <= j + 1'b1;
            state <= S_RDJ;
          end
        end
        S_SCAN: begin
          pv <= 1'b1;
          pidx <= i;
          if (scan_take) begin
            best_cnt <= cnt_rd;
            best <= pidx;
          end
          if (i == last_idx) state <= S_SEL;
          else i <= i + 1'b1;
        end
        S_SEL: begin
          if (scan_take) begin
            best_cnt <= cnt_rd;
            best <= pidx;
          end
          if (best_cnt == '0 && !scan_take) begin
            i <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_ROW;
          end
        end
        S_ROW: begin
          removed[best] <= 1'b1;
          i <= '0;
          pv <= 1'b0;
          state <= S_DEC;
        end
        S_DEC: begin
          pv <= 1'b1;
          pidx <= i;
          if (i == last_idx) state <= S_DECEND;
          else i <= i + 1'b1;
        end
        S_DECEND: begin
          i <= '0;
          pv <= 1'b0;
          best <= '0;
          best_cnt <= '0;
          state <= S_SCAN;
        end
        S_EMIT: begin
          if (removed[i]) begin
            i <= next_live;
          end else if (!valid_out || !stall_out) begin
            state <= S_OUT;
          end
          if (valid_out && !stall_out) valid_out <= 1'b0;
        end
        S_OUT: begin
          kept_x <= xr;
          kept_y <= yr;
          kept_index <= i;
          final_result <= !have_next;
          valid_out <= 1'b1;
          if (have_next) begin
            i <= next_live;
            state <= S_EMIT;
          end else begin
            count <= '0;
            removed <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
      if (state != S_EMIT && state != S_OUT && valid_out && !stall_out)
        valid_out <= 1'b0;
    end
  end
endmodule

// ===== test/min_distance_collision_filter_tb.sv =====
// Testbench for min_distance_collision_filter: loads point sets, predicts survivors of the
// greedy collision removal and checks every emitted point against that prediction.
// Depends on mdcf_pkg and the min_distance_collision_filter RTL.
module min_distance_collision_filter_tb
  import mdcf_pkg::*;
();

  typedef enum logic [1:0] {ROW_POINT, ROW_RADIUS, ROW_GAP} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    logic        typed;
    logic [31:0] cfg;
  } stim_row_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [5:0]  idx;
    logic        fin;
  } kept_t;

  logic              clk, rst;
  logic              psel, penable, pwrite;
  logic [AddrW-1:0]  paddr;
  logic [31:0]       pwdata, prdata;
  logic              pready;
  logic              valid_in, stall_in, valid_out, stall_out;
  logic [CoordW-1:0] x_pos, y_pos, kept_x, kept_y;
  logic              last_point, final_result;
  logic [IdxW-1:0]   kept_index;

  kept_t       kept_q[$];
  stim_row_t   stim_rows[$];
  logic [15:0] set_x[64], set_y[64];
  int          set_n;
  logic [9:0]  cur_radius;
  logic [10:0] cur_gap;
  int          errors, idle_cycles, items_sent;
  int          send_idle_pct, stall_pct;
  int          hold_cnt;
  logic        hold_req, hold_done;

  min_distance_collision_filter uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // greedy max-degree removal over the loaded set, survivors queued in load order
  task automatic resolve_set(input int n, ref kept_t res[$]);
    logic [63:0] adj[64];
    int          cnt[64];
    logic [63:0] gone;
    int          thr, best, best_cnt, last_k;
    longint      lim, dx, dy;
    kept_t       k;
    gone = '0;
    thr = 2 * int'(cur_radius) + int'($signed(cur_gap));
    lim = (thr > 0) ? longint'(thr) * 16 * longint'(thr) * 16 : 0;
    for (int i = 0; i < n; i++) begin
      adj[i] = '0;
      cnt[i] = 0;
    end
    if (thr > 0)
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++) begin
          dx = longint'(set_x[i]) - longint'(set_x[j]);
          dy = longint'(set_y[i]) - longint'(set_y[j]);
          if (dx * dx + dy * dy < lim) begin
            adj[i][j] = 1'b1;
            adj[j][i] = 1'b1;
            cnt[i]++;
            cnt[j]++;
          end
        end
    forever begin
      best = 0;
      best_cnt = 0;
      for (int i = 0; i < n; i++)
        if (!gone[i] && cnt[i] > best_cnt) begin
          best_cnt = cnt[i];
          best = i;
        end
      if (best_cnt == 0) break;
      gone[best] = 1'b1;
      cnt[best] = 0;
      for (int i = 0; i < n; i++)
        if (adj[best][i] && !gone[i] && cnt[i] > 0) cnt[i]--;
    end
    last_k = -1;
    for (int i = 0; i < n; i++)
      if (!gone[i]) begin
        k.x = set_x[i];
        k.y = set_y[i];
        k.idx = 6'(i);
        k.fin = 1'b0;
        res.insert(res.size(), k);
        last_k = res.size() - 1;
      end
    if (last_k >= 0) res[last_k].fin = 1'b1;
  endtask

  task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic last,
                            input logic typed);
    kept_t res[$];
    kept_t k;
    while ($urandom_range(99) < send_idle_pct) begin
      valid_in = 1'b0;
      x_pos = 16'($urandom);
      y_pos = 16'($urandom);
      last_point = 1'($urandom);
      @(negedge clk);
    end
    valid_in = 1'b1;
    x_pos = x;
    y_pos = y;
    last_point = last;
    @(posedge clk);
    while (stall_in) @(posedge clk);
    items_sent++;
    set_x[set_n] = x;
    set_y[set_n] = y;
    set_n++;
    if (last || set_n == MaxPoints) begin
      resolve_set(set_n, res);
      set_n = 0;
      if (typed) begin
        // a lone point always survives as itself
        k.x = x;
        k.y = y;
        k.idx = '0;
        k.fin = 1'b1;
        kept_q.insert(kept_q.size(), k);
      end else
        foreach (res[i]) kept_q.insert(kept_q.size(), res[i]);
    end
    @(negedge clk);
    valid_in = 1'b0;
  endtask

  task automatic drain;
    while (kept_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [31:0] data);
    drain();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == RegRadius) cur_radius = data[9:0];
    else cur_gap = data[10:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic void add_row(row_kind_t kind, logic [15:0] x, logic [15:0] y,
                                  logic last, logic typed, logic [31:0] cfg);
    stim_row_t r;
    r.kind = kind;
    r.x = x;
    r.y = y;
    r.last = last;
    r.typed = typed;
    r.cfg = cfg;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  task automatic random_config;
    int pick;
    pick = $urandom_range(5);
    write_reg(RegRadius, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1023 :
                         (pick < 4) ? 32'($urandom_range(1, 40)) : 32'($urandom_range(1023)));
    pick = $urandom_range(5);
    write_reg(RegGap, (pick == 0) ? 32'h400 : (pick == 1) ? 32'h3FF :
                      (pick < 4) ? 32'($urandom_range(20)) : 32'($urandom_range(2047)));
  endtask

  task automatic random_set(input int n, input logic last_at_end);
    int          thr, spread;
    logic [15:0] bx, by;
    thr = 2 * int'(cur_radius) + int'($signed(cur_gap));
    spread = (thr > 0) ? thr * 40 : 64;
    if (spread > 65535) spread = 65535;
    bx = 16'($urandom);
    by = 16'($urandom);
    for (int i = 0; i < n; i++)
      if ($urandom_range(9) == 0)
        send_point(16'($urandom), 16'($urandom), (i == n - 1) ? last_at_end : 1'b0, 1'b0);
      else
        send_point(bx + 16'($urandom_range(spread)), by + 16'($urandom_range(spread)),
                   (i == n - 1) ? last_at_end : 1'b0, 1'b0);
  endtask

  // receiver side
  initial begin
    stall_out = 1'b1;
    hold_cnt = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_cnt = 500;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        stall_out = 1'b1;
      end else
        stall_out = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (valid_out && !stall_out) begin
      if (kept_q.size() == 0) begin
        $error("unexpected result x=%0h y=%0h index=%0d", kept_x, kept_y, kept_index);
        errors++;
      end else begin
        if (kept_x !== kept_q[0].x) begin
          $error("kept_x expected %0h got %0h", kept_q[0].x, kept_x);
          errors++;
        end
        if (kept_y !== kept_q[0].y) begin
          $error("kept_y expected %0h got %0h", kept_q[0].y, kept_y);
          errors++;
        end
        if (kept_index !== kept_q[0].idx) begin
          $error("kept_index expected %0d got %0d", kept_q[0].idx, kept_index);
          errors++;
        end
        if (final_result !== kept_q[0].fin) begin
          $error("final_result expected %0b got %0b", kept_q[0].fin, final_result);
          errors++;
        end
        void'(kept_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (valid_in && !stall_in) || (valid_out && !stall_out) || (psel && penable))
      idle_cycles <= 0;
    else if (idle_cycles >= 100000) begin
      $display("simulation failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    valid_in = 1'b0;
    x_pos = '0;
    y_pos = '0;
    last_point = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    set_n = 0;
    cur_radius = '0;
    cur_gap = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(ROW_POINT, 16'h0000, 16'h0000, 1, 1, 0);
    add_row(ROW_POINT, 16'hFFFF, 16'hFFFF, 1, 1, 0);
    add_row(ROW_POINT, 16'hAAAA, 16'h5555, 1, 1, 0);
    add_row(ROW_POINT, 16'h0100, 16'h0100, 0, 0, 0);
    add_row(ROW_POINT, 16'h0100, 16'h0100, 0, 0, 0);
    add_row(ROW_POINT, 16'h5000, 16'h5000, 1, 0, 0);
    add_row(ROW_RADIUS, 0, 0, 0, 0, 32'd1023);
    add_row(ROW_GAP, 0, 0, 0, 0, 32'h3FF);
    add_row(ROW_POINT, 16'h0000, 16'h0000, 0, 0, 0);
    add_row(ROW_POINT, 16'h0000, 16'h0000, 0, 0, 0);
    add_row(ROW_POINT, 16'hFFFF, 16'hFFFF, 1, 0, 0);
    add_row(ROW_POINT, 16'h8000, 16'h8000, 0, 0, 0);
    add_row(ROW_POINT, 16'h8010, 16'h8000, 0, 0, 0);
    add_row(ROW_POINT, 16'h8000, 16'h8010, 0, 0, 0);
    add_row(ROW_POINT, 16'h7FF0, 16'h8000, 1, 0, 0);
    add_row(ROW_RADIUS, 0, 0, 0, 0, 32'd0);
    add_row(ROW_GAP, 0, 0, 0, 0, 32'h400);
    add_row(ROW_POINT, 16'h0010, 16'h0010, 0, 0, 0);
    add_row(ROW_POINT, 16'h0010, 16'h0010, 1, 0, 0);
    add_row(ROW_RADIUS, 0, 0, 0, 0, 32'd512);
    add_row(ROW_POINT, 16'h0010, 16'h0010, 0, 0, 0);
    add_row(ROW_POINT, 16'h0010, 16'h0010, 1, 0, 0);
    add_row(ROW_RADIUS, 0, 0, 0, 0, 32'd1);
    add_row(ROW_GAP, 0, 0, 0, 0, 32'd0);
    add_row(ROW_POINT, 16'd1000, 16'd1000, 0, 0, 0);
    add_row(ROW_POINT, 16'd1031, 16'd1000, 0, 0, 0);
    add_row(ROW_POINT, 16'd1000, 16'd1032, 1, 0, 0);

    @(negedge clk);
    foreach (stim_rows[i])
      case (stim_rows[i].kind)
        ROW_POINT: send_point(stim_rows[i].x, stim_rows[i].y, stim_rows[i].last,
                              stim_rows[i].typed);
        ROW_RADIUS: write_reg(RegRadius, stim_rows[i].cfg);
        default: write_reg(RegGap, stim_rows[i].cfg);
      endcase

    // full store without and with the last mark
    drain();
    write_reg(RegRadius, 32'd20);
    write_reg(RegGap, 32'd5);
    random_set(64, 1'b0);
    random_set(64, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 55 : (phase == 3) ? 14 : 0;
      stall_pct = (phase == 2) ? 55 : (phase == 3) ? 14 : 0;
      random_config();
      if (phase == 0) hold_req = 1'b1;
      while (items_sent < 200 + 70 * (phase + 1)) begin
        if ($urandom_range(14) == 0) random_set($urandom_range(33, 64), 1'($urandom));
        else random_set($urandom_range(1, 10), 1'b1);
        if ($urandom_range(3) == 0) random_config();
      end
    end

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
